[design/isp_seq_pkg.sv]
// ----------------------------------------------------------------------------
// isp_seq_pkg
// Shared types and codes for the programming session sequencer.
// ----------------------------------------------------------------------------
package isp_seq_pkg;

   // Width of the target address counter (16..32); it wraps at this width.
   localparam int ADDR_W = 32;

   // Request functions
   localparam logic [2:0] FUNC_SET_LONG = 3'd0;
   localparam logic [2:0] FUNC_CONNECT  = 3'd1;
   localparam logic [2:0] FUNC_RD_FLASH = 3'd2;
   localparam logic [2:0] FUNC_RD_EEP   = 3'd3;
   localparam logic [2:0] FUNC_WR_FLASH = 3'd4;
   localparam logic [2:0] FUNC_WR_EEP   = 3'd5;
   localparam logic [2:0] FUNC_BYTE     = 3'd6;

   // Operations
   localparam logic [2:0] OP_NONE   = 3'd0;
   localparam logic [2:0] OP_RFLASH = 3'd1;
   localparam logic [2:0] OP_REEP   = 3'd2;
   localparam logic [2:0] OP_LOAD   = 3'd3;
   localparam logic [2:0] OP_WFLASH = 3'd4;
   localparam logic [2:0] OP_WEEP   = 3'd5;
   localparam logic [2:0] OP_COMMIT = 3'd6;

   // Status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_STATE = 2'd1;
   localparam logic [1:0] ST_COMPLETE  = 2'd2;

   // Session modes
   localparam logic [2:0] MODE_IDLE   = 3'd0;
   localparam logic [2:0] MODE_WFLASH = 3'd1;
   localparam logic [2:0] MODE_RFLASH = 3'd2;
   localparam logic [2:0] MODE_REEP   = 3'd3;
   localparam logic [2:0] MODE_WEEP   = 3'd4;

   typedef struct packed {
      logic [2:0]  func;
      logic [15:0] value;
      logic [15:0] index;
      logic [15:0] length;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] address;
      logic [7:0]  data;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   // Results of one request: count is 1 or 2, first_rsp goes out first.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first_rsp;
      rsp_type    second_rsp;
   } step_out_type;

endpackage

[design/isp_seq_step.sv]
// ----------------------------------------------------------------------------
// isp_seq_step
// Session state and per-request decode; produces one or two operations.
// ----------------------------------------------------------------------------
module isp_seq_step import isp_seq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  req_type      req,
   output step_out_type step_out
);

   logic [2:0]        mode_ff, mode_in;
   logic [ADDR_W-1:0] next_address_ff, next_address_in;
   logic [15:0]       bytes_left_ff, bytes_left_in;
   logic [11:0]       page_size_ff, page_size_in;
   logic [11:0]       page_left_ff, page_left_in;
   logic              last_block_ff, last_block_in;
   logic              long_mode_ff, long_mode_in;

   logic [15:0]       bytes_dec;
   logic [11:0]       page_dec;
   logic              fin;
   logic              commit;
   logic              open_req;
   logic [2:0]        open_mode;
   logic [2:0]        byte_op;
   logic [1:0]        open_status;
   logic [1:0]        fin_status;
   logic [31:0]       cur_address;

   assign bytes_dec   = bytes_left_ff - 16'd1;
   assign page_dec    = page_left_ff - 12'd1;
   assign fin         = (bytes_dec == 16'd0);
   assign fin_status  = fin ? ST_COMPLETE : ST_OK;
   assign open_status = (req.length == 16'd0) ? ST_COMPLETE : ST_OK;
   assign cur_address = 32'(next_address_ff);

   always_comb begin
      mode_in         = mode_ff;
      next_address_in = next_address_ff;
      bytes_left_in   = bytes_left_ff;
      page_size_in    = page_size_ff;
      page_left_in    = page_left_ff;
      last_block_in   = last_block_ff;
      long_mode_in    = long_mode_ff;
      open_req        = 1'b0;
      open_mode       = MODE_IDLE;
      commit          = 1'b0;
      byte_op         = OP_NONE;

      step_out.count                = 2'd1;
      step_out.first_rsp.op         = OP_NONE;
      step_out.first_rsp.address    = '0;
      step_out.first_rsp.data       = 8'd0;
      step_out.first_rsp.status     = ST_OK;
      step_out.first_rsp.last       = 1'b1;
      step_out.second_rsp.op        = OP_COMMIT;
      step_out.second_rsp.address   = cur_address;
      step_out.second_rsp.data      = req.data_byte;
      step_out.second_rsp.status    = fin_status;
      step_out.second_rsp.last      = 1'b1;

      unique case (req.func)
         FUNC_SET_LONG: begin
            long_mode_in    = 1'b1;
            next_address_in = ADDR_W'({req.index, req.value});
         end
         FUNC_CONNECT: begin
            long_mode_in = 1'b0;
         end
         FUNC_RD_FLASH: begin
            open_req  = 1'b1;
            open_mode = MODE_RFLASH;
         end
         FUNC_RD_EEP: begin
            open_req  = 1'b1;
            open_mode = MODE_REEP;
         end
         FUNC_WR_FLASH: begin
            page_size_in = {req.index[15:12], req.index[7:0]};
            if (req.index[8]) begin
               page_left_in = {req.index[15:12], req.index[7:0]};
            end
            last_block_in = req.index[9];
            open_req      = 1'b1;
            open_mode     = MODE_WFLASH;
         end
         FUNC_WR_EEP: begin
            page_size_in  = 12'd0;
            last_block_in = 1'b0;
            open_req      = 1'b1;
            open_mode     = MODE_WEEP;
         end
         FUNC_BYTE: begin
            if (mode_ff == MODE_IDLE || mode_ff > MODE_WEEP) begin
               step_out.first_rsp.status = ST_BAD_STATE;
            end else begin
               bytes_left_in   = bytes_dec;
               next_address_in = next_address_ff + ADDR_W'(1);
               if (mode_ff == MODE_RFLASH || mode_ff == MODE_REEP) begin
                  byte_op = (mode_ff == MODE_RFLASH) ? OP_RFLASH : OP_REEP;
               end else begin
                  if (mode_ff == MODE_WEEP) begin
                     byte_op = OP_WEEP;
                  end else if (page_size_ff == 12'd0) begin
                     byte_op = OP_WFLASH;
                  end else begin
                     byte_op = OP_LOAD;
                     if (page_dec == 12'd0) begin
                        commit       = 1'b1;
                        page_left_in = page_size_ff;
                     end else begin
                        page_left_in = page_dec;
                     end
                  end
                  if (fin && last_block_ff && (page_left_in != page_size_ff)) begin
                     commit = 1'b1;
                  end
                  step_out.first_rsp.data = req.data_byte;
               end
               if (fin) begin
                  mode_in = MODE_IDLE;
               end
               step_out.first_rsp.op     = byte_op;
               step_out.first_rsp.status = commit ? ST_OK : fin_status;
               step_out.first_rsp.last   = ~commit;
               step_out.count            = commit ? 2'd2 : 2'd1;
            end
         end
         default: begin
         end
      endcase

      if (open_req) begin
         if (!long_mode_ff) begin
            next_address_in = ADDR_W'(req.value);
         end
         bytes_left_in             = req.length;
         mode_in                   = (req.length == 16'd0) ? MODE_IDLE : open_mode;
         step_out.first_rsp.status = open_status;
      end

      // Idle results report the address after this request's update.
      if (step_out.first_rsp.op == OP_NONE) begin
         step_out.first_rsp.address = 32'(next_address_in);
      end else begin
         step_out.first_rsp.address = cur_address;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_IDLE;
         next_address_ff <= '0;
         bytes_left_ff   <= 16'd0;
         page_size_ff    <= 12'd0;
         page_left_ff    <= 12'd0;
         last_block_ff   <= 1'b0;
         long_mode_ff    <= 1'b0;
      end else if (accept) begin
         mode_ff         <= mode_in;
         next_address_ff <= next_address_in;
         bytes_left_ff   <= bytes_left_in;
         page_size_ff    <= page_size_in;
         page_left_ff    <= page_left_in;
         last_block_ff   <= last_block_in;
         long_mode_ff    <= long_mode_in;
      end
   end

endmodule

[design/isp_seq_fifo.sv]
// ----------------------------------------------------------------------------
// isp_seq_fifo
// Four-entry result queue; takes one or two results per push.
// ----------------------------------------------------------------------------
module isp_seq_fifo import isp_seq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  step_out_type push_data,
   input  logic         pop,
   output logic         full2,
   output logic         not_empty,
   output rsp_type      head
);

   rsp_type    entry_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic [2:0] push_cnt;
   logic       do_pop;

   assign do_pop    = pop && (count_ff != 3'd0);
   assign push_cnt  = push ? {1'b0, push_data.count} : 3'd0;
   assign wr_ptr_in = wr_ptr_ff + push_cnt[1:0];
   assign rd_ptr_in = rd_ptr_ff + {1'b0, do_pop};
   assign count_in  = count_ff + push_cnt - {2'b00, do_pop};
   // room for two results is kept so a request never has to wait on a pop
   assign full2     = (count_ff > 3'd2);
   assign not_empty = (count_ff != 3'd0);
   assign head      = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data.first_rsp;
         if (push_data.count == 2'd2) begin
            entry_ff[wr_ptr_ff + 2'd1] <= push_data.second_rsp;
         end
      end
   end

endmodule

[design/isp_programming_session_sequencer_core.sv]
// ----------------------------------------------------------------------------
// isp_programming_session_sequencer_core
// Turns programming-session requests into target memory operations.
// ----------------------------------------------------------------------------
// One request transfer is taken per clock while req_stall is low. Each
// request is decoded in the cycle it is accepted: session registers update
// on that edge and its one or two results (an operation, plus a page commit
// when the page counter runs out or the last block ends on a partial page)
// are written into a four-entry result queue. Results leave one per clock
// while rsp_stall is low, so the sustained rate is one request per cycle
// when each gives one result, and lower for requests that trigger a commit;
// the single read port of the result queue sets that limit. req_stall rises
// while fewer than two queue entries are free, straight from the queue count.
// With the queue empty, a request's first result is offered the next cycle.
// ----------------------------------------------------------------------------
module isp_programming_session_sequencer_core import isp_seq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic         req_accept;
   step_out_type step_out;
   logic         queue_full2;

   // a request transfer completes when valid is high and we are not stalling
   assign req_stall  = queue_full2;
   assign req_accept = req_valid && !queue_full2;

   // session state and request decode
   isp_seq_step u_step (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .req      (req_payload),
      .step_out (step_out)
   );

   // result queue doubles as the output register
   isp_seq_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (step_out),
      .pop       (!rsp_stall),
      .full2     (queue_full2),
      .not_empty (rsp_valid),
      .head      (rsp_payload)
   );

endmodule

[test/isp_programming_session_sequencer_core_tb.sv]
// ----------------------------------------------------------------------------
// isp_programming_session_sequencer_core_tb
// Self-checking bench for the programming session sequencer. It first sends a
// short directed run: address wrap, zero-length transfers, page commits and
// stale page counters. It then sends random programming sessions with random
// content, mixed with noise requests. Four phases use different amounts of
// sender idling and receiver stalling. A predictor tracks session state and
// checks every result transfer field by field, in order.
// ----------------------------------------------------------------------------
module isp_programming_session_sequencer_core_tb;
   import isp_seq_pkg::*;

   localparam logic [31:0] ADDR_MASK = 32'hFFFF_FFFF >> (32 - ADDR_W);
   localparam int PHASE_ITEMS = 410;
   localparam int IDLE_LIMIT  = 2000;   // cycles with no transfer at all
   localparam int HOLD_CYCLES = 80;     // long receiver hold-off

   logic    clock;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   isp_programming_session_sequencer_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // Requests waiting to be driven, and operations the block still owes us.
   req_type request_queue[$];
   rsp_type expected_ops[$];

   // Session state as the predictor sees it.
   logic [2:0]  sess_mode      = MODE_IDLE;
   logic [31:0] sess_addr      = '0;
   logic [15:0] sess_bytes     = '0;
   logic [11:0] sess_page_size = '0;
   logic [11:0] sess_page_left = '0;
   logic        sess_last_blk  = 1'b0;
   logic        sess_long_addr = 1'b0;

   // Traffic shaping, set per phase by the stimulus process.
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_request  = 0;
   int hold_left     = 0;

   logic req_taken = 1'b0;
   int   item_count = 0;
   int   mismatch_count = 0;
   int   idle_cycles = 0;
   int   requests_done = 0;
   int   results_seen = 0;
   int   commits_seen = 0;
   int   bad_state_seen = 0;
   int   completes_seen = 0;
   int   max_pending_seen = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void queue_req(input logic [2:0] f, input logic [15:0] v,
                                     input logic [15:0] idx, input logic [15:0] len,
                                     input logic [7:0] d);
      req_type r;
      r.func      = f;
      r.value     = v;
      r.index     = idx;
      r.length    = len;
      r.data_byte = d;
      request_queue.push_back(r);
      item_count++;
   endfunction

   function automatic void expect_op(input logic [2:0] op, input logic [31:0] a,
                                     input logic [7:0] d, input logic [1:0] st,
                                     input logic lst);
      rsp_type e;
      e.op      = op;
      e.address = a;
      e.data    = d;
      e.status  = st;
      e.last    = lst;
      expected_ops.push_back(e);
   endfunction

   // Opens a read or write transfer; zero length leaves the session idle.
   function automatic logic [1:0] open_session(input logic [2:0] m, input req_type r);
      if (!sess_long_addr)
         sess_addr = {16'd0, r.value} & ADDR_MASK;
      sess_bytes = r.length;
      sess_mode  = (r.length == 16'd0) ? MODE_IDLE : m;
      return (r.length == 16'd0) ? ST_COMPLETE : ST_OK;
   endfunction

   // Predicts the operations caused by one request and updates session state.
   function automatic void sequence_request(input req_type r);
      logic [31:0] here;
      logic [2:0]  wop;
      logic [1:0]  st;
      logic        done;
      logic        commit;
      st = ST_OK;
      case (r.func)
         FUNC_SET_LONG: begin
            sess_long_addr = 1'b1;
            sess_addr = {r.index, r.value} & ADDR_MASK;
         end
         FUNC_CONNECT:  sess_long_addr = 1'b0;
         FUNC_RD_FLASH: st = open_session(MODE_RFLASH, r);
         FUNC_RD_EEP:   st = open_session(MODE_REEP, r);
         FUNC_WR_FLASH: begin
            sess_page_size = {r.index[15:12], r.index[7:0]};
            if (r.index[8])
               sess_page_left = sess_page_size;
            sess_last_blk = r.index[9];
            st = open_session(MODE_WFLASH, r);
         end
         FUNC_WR_EEP: begin
            sess_page_size = '0;
            sess_last_blk  = 1'b0;
            st = open_session(MODE_WEEP, r);
         end
         FUNC_BYTE: begin
            if (sess_mode == MODE_IDLE || sess_mode > MODE_WEEP) begin
               expect_op(OP_NONE, sess_addr, 8'd0, ST_BAD_STATE, 1'b1);
               return;
            end
            here = sess_addr;
            sess_bytes = sess_bytes - 16'd1;
            done = (sess_bytes == 16'd0);
            sess_addr = (sess_addr + 32'd1) & ADDR_MASK;
            if (sess_mode == MODE_RFLASH || sess_mode == MODE_REEP) begin
               wop = (sess_mode == MODE_RFLASH) ? OP_RFLASH : OP_REEP;
               if (done)
                  sess_mode = MODE_IDLE;
               expect_op(wop, here, 8'd0, done ? ST_COMPLETE : ST_OK, 1'b1);
               return;
            end
            commit = 1'b0;
            if (sess_mode == MODE_WEEP) begin
               wop = OP_WEEP;
            end else if (sess_page_size == 12'd0) begin
               wop = OP_WFLASH;
            end else begin
               wop = OP_LOAD;
               sess_page_left = sess_page_left - 12'd1;
               if (sess_page_left == 12'd0) begin
                  commit = 1'b1;
                  sess_page_left = sess_page_size;
               end
            end
            // end of the last block flushes a partly filled page
            if (done) begin
               sess_mode = MODE_IDLE;
               if (sess_last_blk && sess_page_left != sess_page_size)
                  commit = 1'b1;
            end
            if (commit) begin
               expect_op(wop, here, r.data_byte, ST_OK, 1'b0);
               expect_op(OP_COMMIT, here, r.data_byte, done ? ST_COMPLETE : ST_OK, 1'b1);
            end else begin
               expect_op(wop, here, r.data_byte, done ? ST_COMPLETE : ST_OK, 1'b1);
            end
            return;
         end
         default: ;
      endcase
      expect_op(OP_NONE, sess_addr, 8'd0, st, 1'b1);
   endfunction

   // One random session: mostly a well-formed transfer, sometimes noise,
   // cut short or followed by a stray byte.
   function automatic void add_session();
      int          roll;
      int          n;
      int          ps_pick;
      logic [2:0]  f;
      logic [11:0] ps;
      logic [15:0] idx;
      roll = $urandom_range(0, 99);
      if (roll >= 80) begin
         queue_req(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom),
                   16'($urandom), 8'($urandom));
         return;
      end
      if (roll < 8)
         queue_req(FUNC_SET_LONG, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
      else if (roll < 14)
         queue_req(FUNC_CONNECT, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
      case ($urandom_range(0, 3))
         0:       f = FUNC_RD_FLASH;
         1:       f = FUNC_RD_EEP;
         2:       f = FUNC_WR_FLASH;
         default: f = FUNC_WR_EEP;
      endcase
      n = $urandom_range(1, 20);
      idx = 16'($urandom);
      if (f == FUNC_WR_FLASH) begin
         ps_pick = $urandom_range(0, 9);
         if (ps_pick == 0)
            ps = 12'd0;
         else if (ps_pick == 9)
            ps = 12'($urandom);
         else
            ps = 12'($urandom_range(1, 8));
         idx[15:12] = ps[11:8];
         idx[7:0]   = ps[7:0];
         idx[8]     = ($urandom_range(0, 4) != 0);   // first block, mostly
      end
      queue_req(f, 16'($urandom), idx, 16'(n), 8'($urandom));
      if ($urandom_range(0, 9) == 0)
         n = $urandom_range(0, n - 1);
      for (int k = 0; k < n; k++)
         queue_req(FUNC_BYTE, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
      if ($urandom_range(0, 9) == 0)
         queue_req(FUNC_BYTE, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
   endfunction

   task automatic wait_drained();
      while (!(request_queue.size() == 0 && !req_valid && expected_ops.size() == 0))
         @(negedge clock);
   endtask

   // Request driver: a stalled transfer keeps its payload.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid   <= 1'b1;
            req_payload <= request_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result stall: random, or a long hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Monitor: check result transfers, then predict from request transfers.
   always @(posedge clock) begin
      rsp_type want;
      req_taken = !reset && req_valid && !req_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (rsp_payload.op == OP_COMMIT)
               commits_seen++;
            if (rsp_payload.status == ST_BAD_STATE)
               bad_state_seen++;
            if (rsp_payload.status == ST_COMPLETE)
               completes_seen++;
            if (expected_ops.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result: op %0d addr %h data %h status %0d last %0d",
                           rsp_payload.op, rsp_payload.address, rsp_payload.data,
                           rsp_payload.status, rsp_payload.last);
            end else begin
               want = expected_ops.pop_front();
               if (rsp_payload.op !== want.op || rsp_payload.address !== want.address ||
                   rsp_payload.data !== want.data || rsp_payload.status !== want.status ||
                   rsp_payload.last !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: exp op %0d addr %h data %h status %0d last %0d, got op %0d addr %h data %h status %0d last %0d",
                              want.op, want.address, want.data, want.status, want.last,
                              rsp_payload.op, rsp_payload.address, rsp_payload.data,
                              rsp_payload.status, rsp_payload.last);
               end
            end
         end
         if (req_taken) begin
            requests_done++;
            sequence_request(req_payload);
         end
         if (expected_ops.size() > max_pending_seen)
            max_pending_seen = expected_ops.size();
         // watchdog on cycles without any transfer
         if (req_taken || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      int start;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: idle byte, unknown function, zero length.
      queue_req(FUNC_BYTE, 16'h0000, 16'h0000, 16'h0000, 8'hFF);
      queue_req(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
      queue_req(FUNC_RD_FLASH, 16'hFFFF, 16'h0000, 16'h0000, 8'h00);
      // Long address near the top, read wraps through zero.
      queue_req(FUNC_SET_LONG, 16'hFFFE, 16'hFFFF, 16'h0000, 8'h00);
      queue_req(FUNC_RD_EEP, 16'h1234, 16'h0000, 16'h0003, 8'h00);
      for (int k = 0; k < 3; k++)
         queue_req(FUNC_BYTE, 16'h0000, 16'h0000, 16'h0000, 8'(k));
      queue_req(FUNC_CONNECT, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      queue_req(FUNC_RD_FLASH, 16'h0040, 16'h0000, 16'h0001, 8'h00);
      queue_req(FUNC_BYTE, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      // Page of two, first and last block, three bytes: commit on page
      // rollover, then again on the partial page at the end.
      queue_req(FUNC_WR_FLASH, 16'h0100, 16'h0302, 16'h0003, 8'h00);
      queue_req(FUNC_BYTE, 16'h0000, 16'h0000, 16'h0000, 8'hA5);
      queue_req(FUNC_BYTE, 16'h0000, 16'h0000, 16'h0000, 8'h5A);
      queue_req(FUNC_BYTE, 16'h0000, 16'h0000, 16'h0000, 8'hFF);
      // Largest page, then a page-less last block with a stale counter.
      queue_req(FUNC_WR_FLASH, 16'h0200, 16'hF1FF, 16'h0002, 8'h00);
      queue_req(FUNC_BYTE, 16'h0000, 16'h0000, 16'h0000, 8'h11);
      queue_req(FUNC_BYTE, 16'h0000, 16'h0000, 16'h0000, 8'h22);
      queue_req(FUNC_WR_FLASH, 16'h0300, 16'h0200, 16'h0001, 8'h00);
      queue_req(FUNC_BYTE, 16'h0000, 16'h0000, 16'h0000, 8'h33);
      // EEPROM write at the top of the 16-bit range.
      queue_req(FUNC_WR_EEP, 16'hFFFF, 16'h0000, 16'h0002, 8'h00);
      queue_req(FUNC_BYTE, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      queue_req(FUNC_BYTE, 16'h0000, 16'h0000, 16'h0000, 8'hFF);
      // Longest transfer, left open and overrun by later requests.
      queue_req(FUNC_WR_FLASH, 16'h0000, 16'h0000, 16'hFFFF, 8'h00);
      queue_req(FUNC_CONNECT, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      queue_req(FUNC_BYTE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h80);
      wait_drained();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 57; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 57; end
            default: begin send_idle_pct = 24; stall_pct = 24; end
         endcase
         start = item_count;
         while (item_count - start < PHASE_ITEMS)
            add_session();
         // first phase: the receiver holds off while requests keep coming
         if (ph == 0) begin
            @(posedge clock);
            hold_request = HOLD_CYCLES;
         end
         wait_drained();
      end

      repeat (10) @(negedge clock);
      mismatch_count += expected_ops.size();
      $display("covered %0d requests, %0d results: %0d commits, %0d bad-state bytes, %0d completions",
               requests_done, results_seen, commits_seen, bad_state_seen, completes_seen);
      $display("four idle/stall phases plus a %0d-cycle hold-off; peak outstanding results %0d",
               HOLD_CYCLES, max_pending_seen);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
